// ===== rtl/glzw_pkg.sv =====
// Shared types and constants for the GIF LZW decoder.
package glzw_pkg;

   typedef enum logic [2:0] {
      ST_TAKEN   = 3'd0,
      ST_REFUSED = 3'd1,
      ST_PIXEL   = 3'd2,
      ST_NEED    = 3'd3,
      ST_END     = 3'd4,
      ST_BAD     = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      ACT_FEED = 1'b0,
      ACT_PULL = 1'b1
   } action_type;

   typedef struct packed {
      action_type action;
      logic [7:0] data_byte;
   } cmd_type;

   typedef struct packed {
      status_type status;
      logic [7:0] pixel_index;
      logic       last_of_string;
   } rsp_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_CODE,
      EX_RDWAIT,
      EX_WALK,
      EX_POPRD,
      EX_POPOUT
   } exec_state_type;

   function automatic logic [3:0] eff_size(input logic [3:0] mcs);
      logic [3:0] r;
      r = mcs;
      if (mcs < 4'd2) r = 4'd2;
      if (mcs > 4'd8) r = 4'd8;
      return r;
   endfunction

endpackage

// ===== rtl/glzw_front.sv =====
// Input front end: accepts transactions and queues decoded commands.
module glzw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  flush,
   input  logic                  s_valid,
   output logic                  s_ready,
   input  glzw_pkg::cmd_type     s_cmd,
   output logic                  q_valid,
   input  logic                  q_ready,
   output glzw_pkg::cmd_type     q_cmd
);
   import glzw_pkg::*;

   cmd_type    mem_ff [2];
   logic [0:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign s_ready = (cnt_ff != 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = mem_ff[rp_ff];
   assign push    = s_valid && s_ready;
   assign pop     = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= s_cmd;
      end
   end
endmodule

// ===== rtl/glzw_back.sv =====
// Decoder back end: bit buffer, dictionary walk, string stack and result register.
module glzw_back #(
   parameter int DICT_ENTRIES  = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic [3:0]            min_code_size,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  glzw_pkg::cmd_type     q_cmd,
   output logic                  m_valid,
   input  logic                  m_ready,
   output glzw_pkg::rsp_type     m_rsp
);
   import glzw_pkg::*;

   localparam int AW = $clog2(DICT_ENTRIES);
   localparam int CW = MAX_CODE_BITS;

   logic [CW-1:0] prefix_mem [DICT_ENTRIES];
   logic [7:0]    suffix_mem [DICT_ENTRIES];
   logic [7:0]    stack_mem  [DICT_ENTRIES];

   exec_state_type st_ff, st_in;
   logic [31:0]   buf_ff, buf_in;
   logic [5:0]    bcnt_ff, bcnt_in;
   logic [AW:0]   nfc_ff, nfc_in;
   logic [3:0]    cw_ff, cw_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic          pvalid_ff, pvalid_in;
   logic [7:0]    pfirst_ff, pfirst_in;
   logic [AW:0]   sl_ff, sl_in;
   logic          end_ff, end_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [CW-1:0] code_ff, code_in;
   logic          addf_ff, addf_in;
   logic          ov_ff, ov_in;
   rsp_type       ov_rsp_ff, ov_rsp_in;
   logic          take;

   logic [CW-1:0] pre_rd_ff;
   logic [7:0]    suf_rd_ff, stk_rd_ff;
   logic [AW-1:0] dict_raddr, stk_raddr, stk_waddr;
   logic          stk_we;
   logic [7:0]    stk_wdata;
   logic          dict_we;
   logic [AW-1:0] dict_waddr;
   logic [CW-1:0] dict_wpre;
   logic [7:0]    dict_wsuf;

   logic [3:0]    size;
   logic [AW:0]   clr, eoi;
   logic [31:0]   mask;
   logic [CW-1:0] code_w;
   logic [AW:0]   code_x;
   logic          emit;
   rsp_type       emit_rsp;

   assign size   = eff_size(min_code_size);
   assign clr    = (AW+1)'(1) << size;
   assign eoi    = clr + 1'b1;
   assign mask   = (32'd1 << cw_ff) - 32'd1;
   assign code_w = CW'(buf_ff & mask);
   assign code_x = (AW+1)'(code_w);
   assign m_valid = ov_ff;
   assign m_rsp   = ov_rsp_ff;
   assign take    = !ov_ff || m_ready;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         EX_IDLE: begin
            if (q_valid && take) begin
               if (q_cmd.action == ACT_PULL) begin
                  if (sl_ff != '0) st_in = EX_POPRD;
                  else if (!end_ff) st_in = EX_CODE;
               end
            end
         end
         EX_CODE: begin
            if (bcnt_ff < {2'b0, cw_ff}) st_in = EX_IDLE;
            else if (code_x == clr) st_in = EX_CODE;
            else if (code_x == eoi) st_in = EX_IDLE;
            else if (code_x < clr || code_x < nfc_ff) st_in = EX_RDWAIT;
            else if (code_x == nfc_ff && pvalid_ff && nfc_ff < DICT_ENTRIES)
               st_in = EX_RDWAIT;
            else st_in = EX_IDLE;
         end
         EX_RDWAIT: st_in = EX_WALK;
         EX_WALK: begin
            if (!((AW+1)'(walk_ff) > eoi && sl_ff < DICT_ENTRIES - 1))
               st_in = EX_POPRD;
            else st_in = EX_RDWAIT;
         end
         EX_POPRD: st_in = EX_POPOUT;
         EX_POPOUT: if (take) st_in = EX_IDLE;
         default: st_in = EX_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      buf_in = buf_ff; bcnt_in = bcnt_ff; nfc_in = nfc_ff; cw_in = cw_ff;
      prev_in = prev_ff; pvalid_in = pvalid_ff; pfirst_in = pfirst_ff;
      sl_in = sl_ff; end_in = end_ff; walk_in = walk_ff; code_in = code_ff;
      addf_in = addf_ff;
      q_ready = 1'b0; emit = 1'b0;
      emit_rsp = '{status: ST_TAKEN, pixel_index: 8'd0, last_of_string: 1'b0};
      dict_raddr = walk_ff[AW-1:0];
      stk_raddr  = AW'(sl_ff - 1'b1);
      stk_we = 1'b0; stk_waddr = sl_ff[AW-1:0]; stk_wdata = 8'd0;
      dict_we = 1'b0; dict_waddr = nfc_ff[AW-1:0]; dict_wpre = prev_ff;
      dict_wsuf = 8'd0;
      unique case (st_ff)
         EX_IDLE: begin
            if (q_valid && take) begin
               q_ready = 1'b1;
               if (q_cmd.action == ACT_FEED) begin
                  emit = 1'b1;
                  if (bcnt_ff <= 6'd24) begin
                     buf_in  = buf_ff | ({24'd0, q_cmd.data_byte} << bcnt_ff[4:0]);
                     bcnt_in = bcnt_ff + 6'd8;
                  end else emit_rsp.status = ST_REFUSED;
               end else if (sl_ff == '0 && end_ff) begin
                  emit = 1'b1;
                  emit_rsp.status = ST_END;
               end
            end
         end
         EX_CODE: begin
            if (bcnt_ff < {2'b0, cw_ff}) begin
               emit = 1'b1; emit_rsp.status = ST_NEED;
            end else begin
               buf_in  = buf_ff >> cw_ff;
               bcnt_in = bcnt_ff - {2'b0, cw_ff};
               code_in = code_w;
               walk_in = code_w;
               if (code_x == clr) begin
                  nfc_in = clr + 2'd2; cw_in = size + 4'd1; pvalid_in = 1'b0;
               end else if (code_x == eoi) begin
                  end_in = 1'b1; emit = 1'b1; emit_rsp.status = ST_END;
               end else if (code_x < clr || code_x < nfc_ff) begin
                  addf_in = pvalid_ff;
               end else if (code_x == nfc_ff && pvalid_ff && nfc_ff < DICT_ENTRIES) begin
                  // KwKwK: add entry with previous first symbol before walking.
                  addf_in = 1'b0;
                  dict_we = 1'b1; dict_wsuf = pfirst_ff;
                  nfc_in = nfc_ff + 1'b1;
                  if (cw_ff < MAX_CODE_BITS && (nfc_ff + 1'b1) == ((AW+1)'(1) << cw_ff))
                     cw_in = cw_ff + 4'd1;
               end else begin
                  emit = 1'b1; emit_rsp.status = ST_BAD;
               end
            end
         end
         EX_RDWAIT: begin
            dict_raddr = walk_ff[AW-1:0];
         end
         EX_WALK: begin
            if ((AW+1)'(walk_ff) > eoi && sl_ff < DICT_ENTRIES - 1) begin
               stk_we = 1'b1; stk_wdata = suf_rd_ff;
               sl_in = sl_ff + 1'b1;
               walk_in = pre_rd_ff;
            end else begin
               // Push the first symbol, then record and maybe add an entry.
               if (sl_ff < DICT_ENTRIES) begin
                  stk_we = 1'b1; stk_wdata = walk_ff[7:0];
                  sl_in = sl_ff + 1'b1;
               end
               stk_raddr = AW'(sl_in - 1'b1);
               if (addf_ff && nfc_ff < DICT_ENTRIES) begin
                  dict_we = 1'b1; dict_wsuf = walk_ff[7:0];
                  nfc_in = nfc_ff + 1'b1;
                  if (cw_ff < MAX_CODE_BITS && (nfc_ff + 1'b1) == ((AW+1)'(1) << cw_ff))
                     cw_in = cw_ff + 4'd1;
               end
               addf_in = 1'b0;
               prev_in = code_ff; pfirst_in = walk_ff[7:0]; pvalid_in = 1'b1;
            end
         end
         EX_POPRD: begin
         end
         EX_POPOUT: begin
            if (take) begin
               emit = 1'b1;
               emit_rsp.status = ST_PIXEL;
               emit_rsp.pixel_index = stk_rd_ff;
               emit_rsp.last_of_string = (sl_ff == (AW+1)'(1));
               sl_in = sl_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      ov_in = ov_ff; ov_rsp_in = ov_rsp_ff;
      if (m_ready) ov_in = 1'b0;
      if (emit) begin
         ov_in = 1'b1; ov_rsp_in = emit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         st_ff <= EX_IDLE; buf_ff <= '0; bcnt_ff <= '0;
         nfc_ff <= clr + 2'd2; cw_ff <= size + 4'd1;
         prev_ff <= '0; pvalid_ff <= 1'b0; pfirst_ff <= '0;
         sl_ff <= '0; end_ff <= 1'b0; addf_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; buf_ff <= buf_in; bcnt_ff <= bcnt_in;
         nfc_ff <= nfc_in; cw_ff <= cw_in; prev_ff <= prev_in;
         pvalid_ff <= pvalid_in; pfirst_ff <= pfirst_in; sl_ff <= sl_in;
         end_ff <= end_in; addf_ff <= addf_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in; code_ff <= code_in; ov_rsp_ff <= ov_rsp_in;
   end

   always_ff @(posedge clock) begin
      if (dict_we) begin
         prefix_mem[dict_waddr] <= dict_wpre;
         suffix_mem[dict_waddr] <= dict_wsuf;
      end
      pre_rd_ff <= prefix_mem[dict_raddr];
      suf_rd_ff <= suffix_mem[dict_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stack_mem[stk_raddr];
   end
endmodule

// ===== rtl/gif_lzw_decoder.sv =====
// Top level of the GIF LZW decoder.
// Usage:
//  req_ channel carries one command per transaction: tuser = action
//  (0 feed a data byte, 1 pull a pixel), tdata[7:0] = data byte.
//  rsp_ channel returns exactly one result per command: tuser[2:0] status,
//  tdata[7:0] pixel index, tlast marks the pixel that ends a code's string.
//  csr_ writes min_code_size and restarts decoding; write only while idle.
// Execution steps (from command acceptance to result valid, queue empty):
//  A feed, a refused feed or an end report: dispatch only.
//  A pull with pixels pending: dispatch, stack read, pop.
//  A pull that starts a new code: dispatch, then a code read per code
//  (clears included), then per symbol of the string the registered
//  prefix/suffix read and the stack push, then the stack read and the pop.
//  Need data and bad code finish in the last code read.
//  A two-entry queue decouples acceptance from execution; a result
//  register holds a finished result while the receiver stalls, and the
//  back end waits for it to be taken before emitting another.
// Reset: synchronous, active high; clears all control state.
// Dictionary and stack memories are not cleared.
module gif_lzw_decoder #(
   parameter int DICT_ENTRIES  = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_index
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   import glzw_pkg::*;

   logic [3:0] mcs_ff;
   logic [3:0] mcs_eff;
   cmd_type    s_cmd, q_cmd;
   logic       q_valid, q_ready;
   rsp_type    m_rsp;

   // Hold the code size register; reset value is 8.
   always_ff @(posedge clock) begin
      if (reset) mcs_ff <= 4'd8;
      else if (csr_we) mcs_ff <= csr_wdata;
   end

   // Size seen by the back end: reset value during reset, new value on a write.
   assign mcs_eff = reset ? 4'd8 : (csr_we ? csr_wdata : mcs_ff);

   assign s_cmd.action    = action_type'(req_tuser);
   assign s_cmd.data_byte = req_tdata;

   glzw_front u_front (
      .clock(clock), .reset(reset), .flush(csr_we),
      .s_valid(req_tvalid), .s_ready(req_tready), .s_cmd(s_cmd),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   glzw_back #(.DICT_ENTRIES(DICT_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
      .clock(clock), .reset(reset), .restart(csr_we), .min_code_size(mcs_eff),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .m_valid(rsp_tvalid), .m_ready(rsp_tready), .m_rsp(m_rsp)
   );

   assign rsp_tdata = m_rsp.pixel_index;
   assign rsp_tuser = m_rsp.status;
   assign rsp_tlast = m_rsp.last_of_string;
endmodule
